>>> hw/rtl/kwl_pkg.sv
// shared types, constants and character-class helpers for the keyword/number lexer
// depends on nothing; imported by kwl_scan, kwl_outq, the top level and the testbench

package kwl_pkg;

  localparam int IDENT_CHARS = 8;

  localparam logic [15:0] POS_MAX = 16'hFFFF;
  localparam logic [62:0] NUM_MAX = {63{1'b1}};

  // keyword spellings, first byte in the low bits
  localparam logic [63:0] KW_REPEAT = 64'h0000_7461_6570_6572;
  localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_DEF    = 64'h0000_0000_0066_6564;
  localparam logic [63:0] KW_TRUE   = 64'h0000_0000_6575_7274;
  localparam logic [63:0] KW_FALSE  = 64'h0000_0065_736C_6166;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SUFFIX  = 8'h73;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOT  = 1'b1;

  typedef enum logic [3:0] {
    K_EOF      = 4'd0,
    K_LPAREN   = 4'd1,
    K_RPAREN   = 4'd2,
    K_LBRACE   = 4'd3,
    K_RBRACE   = 4'd4,
    K_COMMA    = 4'd5,
    K_REPEAT   = 4'd6,
    K_IF       = 4'd7,
    K_DEF      = 4'd8,
    K_BOOL     = 4'd9,
    K_IDENT    = 4'd10,
    K_NUMBER   = 4'd11,
    K_DURATION = 4'd12,
    K_ERROR    = 4'd13
  } kind_e;

  typedef struct packed {
    kind_e       token_kind;
    logic [15:0] token_line;
    logic [15:0] token_col;
    logic        bool_val;
    logic [62:0] num_val;
    logic [63:0] ident_text;
    logic [7:0]  ident_len;
    logic        ident_truncated;
    logic        last_of_run;
  } token_t;

  // up to two tokens produced by one item
  typedef struct packed {
    logic [1:0] cnt;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v != POS_MAX) ? v + 16'd1 : v;
  endfunction

endpackage

>>> hw/rtl/kwl_in_if.sv
// input channel of the lexer: one text byte or end of text per item
// depends on nothing

interface kwl_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] ch;

  modport source (output valid, output req_type, output ch, input ready);
  modport sink (input valid, input req_type, input ch, output ready);
endinterface

>>> hw/rtl/kwl_out_if.sv
// output channel of the lexer: one token per item
// depends on nothing

interface kwl_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] token_line;
  logic [15:0] token_col;
  logic        bool_val;
  logic [62:0] num_val;
  logic [63:0] ident_text;
  logic [7:0]  ident_len;
  logic        ident_truncated;
  logic        last_of_run;

  modport source (
    output valid, output token_kind, output token_line, output token_col,
    output bool_val, output num_val, output ident_text, output ident_len,
    output ident_truncated, output last_of_run, input ready
  );
  modport sink (
    input valid, input token_kind, input token_line, input token_col,
    input bool_val, input num_val, input ident_text, input ident_len,
    input ident_truncated, input last_of_run, output ready
  );
endinterface

>>> hw/rtl/kwl_scan.sv
// scanner state and single-pass step logic: one item in, up to two tokens out
// depends on kwl_pkg

module kwl_scan import kwl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       req_type_i,
  input  logic [7:0] ch_i,
  output push_t      push_o
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WORD = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_DEAD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SUF_NONE = 2'd0,
    SUF_S    = 2'd1,
    SUF_BAD  = 2'd2
  } suffix_e;

  mode_e       mode_q, mode_d;
  suffix_e     suf_q, suf_d;
  logic [15:0] cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [15:0] start_line_q, start_line_d, start_col_q, start_col_d;
  logic [63:0] word_buf_q, word_buf_d;
  logic [7:0]  word_len_q, word_len_d;
  logic [62:0] num_acc_q, num_acc_d;

  token_t      word_tok, num_tok, base_tok;
  logic [66:0] acc_next;

  // pending word as a token
  always_comb begin
    word_tok            = '0;
    word_tok.token_line = start_line_q;
    word_tok.token_col  = start_col_q;
    if (word_len_q == 8'd6 && word_buf_q == KW_REPEAT) begin
      word_tok.token_kind = K_REPEAT;
    end else if (word_len_q == 8'd2 && word_buf_q == KW_IF) begin
      word_tok.token_kind = K_IF;
    end else if (word_len_q == 8'd3 && word_buf_q == KW_DEF) begin
      word_tok.token_kind = K_DEF;
    end else if (word_len_q == 8'd4 && word_buf_q == KW_TRUE) begin
      word_tok.token_kind = K_BOOL;
      word_tok.bool_val   = 1'b1;
    end else if (word_len_q == 8'd5 && word_buf_q == KW_FALSE) begin
      word_tok.token_kind = K_BOOL;
    end else begin
      word_tok.token_kind      = K_IDENT;
      word_tok.ident_text      = word_buf_q;
      word_tok.ident_len       = word_len_q;
      word_tok.ident_truncated = word_len_q > 8'(IDENT_CHARS);
    end
  end

  // pending number as a token
  always_comb begin
    num_tok            = '0;
    num_tok.token_line = start_line_q;
    num_tok.token_col  = start_col_q;
    if (suf_q == SUF_BAD) begin
      num_tok.token_kind = K_ERROR;
    end else begin
      num_tok.token_kind = (suf_q == SUF_S) ? K_DURATION : K_NUMBER;
      num_tok.num_val    = num_acc_q;
    end
  end

  // acc * 10 + digit, saturates when it leaves 63 bits
  assign acc_next = ({4'd0, num_acc_q} << 3) + ({4'd0, num_acc_q} << 1) + 67'(ch_i[3:0]);

  always_comb begin
    token_t  res [2];
    logic [1:0] n;
    logic       do_idle;
    token_t  t;

    res[0]       = '0;
    res[1]       = '0;
    n            = 2'd0;
    do_idle      = 1'b0;
    t            = '0;
    mode_d       = mode_q;
    suf_d        = suf_q;
    cur_line_d   = cur_line_q;
    cur_col_d    = cur_col_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    word_buf_d   = word_buf_q;
    word_len_d   = word_len_q;
    num_acc_d    = num_acc_q;
    base_tok            = '0;
    base_tok.token_line = cur_line_q;
    base_tok.token_col  = cur_col_q;

    if (step_i) begin
      if (req_type_i == REQ_EOT) begin
        if (mode_q == MODE_WORD) begin
          res[n[0]] = word_tok;
          n         = n + 2'd1;
        end else if (mode_q == MODE_NUM) begin
          res[n[0]] = num_tok;
          n         = n + 2'd1;
        end
        if (!(mode_q == MODE_DEAD || (mode_q == MODE_NUM && suf_q == SUF_BAD))) begin
          t            = base_tok;
          t.token_kind = K_EOF;
          res[n[0]]    = t;
          n            = n + 2'd1;
        end
        mode_d       = MODE_IDLE;
        suf_d        = SUF_NONE;
        cur_line_d   = 16'd1;
        cur_col_d    = 16'd1;
        start_line_d = 16'd1;
        start_col_d  = 16'd1;
        word_buf_d   = '0;
        word_len_d   = '0;
        num_acc_d    = '0;
      end else if (mode_q == MODE_WORD) begin
        if (is_alpha(ch_i)) begin
          if (word_len_q < 8'(IDENT_CHARS)) begin
            word_buf_d[word_len_q[2:0]*8 +: 8] = ch_i;
          end
          if (word_len_q != 8'hFF) begin
            word_len_d = word_len_q + 8'd1;
          end
          cur_col_d = sat_inc(cur_col_q);
        end else begin
          res[n[0]] = word_tok;
          n         = n + 2'd1;
          mode_d    = MODE_IDLE;
          do_idle   = 1'b1;
        end
      end else if (mode_q == MODE_NUM) begin
        if (is_alpha(ch_i) || is_digit(ch_i)) begin
          if (suf_q == SUF_NONE) begin
            if (is_digit(ch_i)) begin
              num_acc_d = (acc_next[66:63] != 4'd0) ? NUM_MAX : acc_next[62:0];
            end else if (ch_i == CH_SUFFIX) begin
              suf_d = SUF_S;
            end else begin
              suf_d = SUF_BAD;
            end
          end else begin
            suf_d = SUF_BAD;
          end
          cur_col_d = sat_inc(cur_col_q);
        end else begin
          res[n[0]] = num_tok;
          n         = n + 2'd1;
          if (suf_q == SUF_BAD) begin
            mode_d = MODE_DEAD;
          end else begin
            mode_d  = MODE_IDLE;
            do_idle = 1'b1;
          end
        end
      end else if (mode_q == MODE_IDLE) begin
        do_idle = 1'b1;
      end

      // between tokens: whitespace, punctuation, start of a run, or an error byte
      if (do_idle) begin
        t = base_tok;
        if (is_space(ch_i)) begin
          if (ch_i == CH_NEWLINE) begin
            cur_col_d  = 16'd1;
            cur_line_d = sat_inc(cur_line_q);
          end else begin
            cur_col_d = sat_inc(cur_col_q);
          end
        end else if (ch_i == CH_LPAREN || ch_i == CH_RPAREN || ch_i == CH_LBRACE ||
                     ch_i == CH_RBRACE || ch_i == CH_COMMA) begin
          case (ch_i)
            CH_LPAREN: t.token_kind = K_LPAREN;
            CH_RPAREN: t.token_kind = K_RPAREN;
            CH_LBRACE: t.token_kind = K_LBRACE;
            CH_RBRACE: t.token_kind = K_RBRACE;
            default:   t.token_kind = K_COMMA;
          endcase
          res[n[0]] = t;
          n         = n + 2'd1;
          cur_col_d = sat_inc(cur_col_q);
        end else begin
          start_line_d = cur_line_q;
          start_col_d  = cur_col_q;
          if (is_alpha(ch_i)) begin
            word_buf_d = 64'(ch_i);
            word_len_d = 8'd1;
            mode_d     = MODE_WORD;
            cur_col_d  = sat_inc(cur_col_q);
          end else if (is_digit(ch_i)) begin
            num_acc_d = 63'(ch_i[3:0]);
            suf_d     = SUF_NONE;
            mode_d    = MODE_NUM;
            cur_col_d = sat_inc(cur_col_q);
          end else begin
            t.token_kind = K_ERROR;
            res[n[0]]    = t;
            n            = n + 2'd1;
            mode_d       = MODE_DEAD;
          end
        end
      end
    end

    if (n == 2'd1) res[0].last_of_run = 1'b1;
    if (n == 2'd2) res[1].last_of_run = 1'b1;

    push_o.cnt  = n;
    push_o.tok0 = res[0];
    push_o.tok1 = res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      suf_q        <= SUF_NONE;
      cur_line_q   <= 16'd1;
      cur_col_q    <= 16'd1;
      start_line_q <= 16'd1;
      start_col_q  <= 16'd1;
      word_buf_q   <= '0;
      word_len_q   <= '0;
      num_acc_q    <= '0;
    end else begin
      mode_q       <= mode_d;
      suf_q        <= suf_d;
      cur_line_q   <= cur_line_d;
      cur_col_q    <= cur_col_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      word_buf_q   <= word_buf_d;
      word_len_q   <= word_len_d;
      num_acc_q    <= num_acc_d;
    end
  end

endmodule

>>> hw/rtl/kwl_outq.sv
// four-entry token queue: takes up to two tokens a cycle, gives one while ready_i is high
// depends on kwl_pkg

module kwl_outq import kwl_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  output logic   room_o,
  output logic   valid_o,
  input  logic   ready_i,
  output token_t tok_o
);

  token_t     mem_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;
  logic       pop;

  assign valid_o = count_q != 3'd0;
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rd_ptr_q];
  // room for the worst case of two tokens
  assign room_o  = count_q <= 3'd2;

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr_q + 2'd1] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_i.cnt;
      rd_ptr_q <= rd_ptr_q + 2'(pop);
      count_q  <= count_q + 3'(push_i.cnt) - 3'(pop);
    end
  end

endmodule

>>> hw/rtl/keyword_number_lexer_top.sv
// top level of the keyword/number lexer: input register, scanner, token queue
// depends on kwl_pkg, kwl_in_if, kwl_out_if, kwl_scan, kwl_outq
// an accepted item is held in the input register until the queue has room for two tokens
// throughput: one item per cycle while the queue has room; the single output port drains
//   one token per cycle when ready, so two-token items are bounded by the four-entry queue
// reset: rst_ni clears the scanner to line 1, column 1, idle, and empties the queue

module keyword_number_lexer_top import kwl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  kwl_in_if.sink    req_i,
  kwl_out_if.source tok_o
);

  // input register
  logic       in_vld_q;
  logic       in_type_q;
  logic [7:0] in_ch_q;

  logic   step;
  logic   room;
  push_t  push;
  token_t head;

  // the register item is scanned when the queue can take two tokens
  assign step        = in_vld_q && room;
  // refill the input register while its item is being scanned
  assign req_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_type_q <= req_i.req_type;
      in_ch_q   <= req_i.ch;
    end
  end

  kwl_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .req_type_i (in_type_q),
    .ch_i       (in_ch_q),
    .push_o     (push)
  );

  kwl_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (tok_o.valid),
    .ready_i (tok_o.ready),
    .tok_o   (head)
  );

  // unpack the head token onto the channel
  assign tok_o.token_kind      = head.token_kind;
  assign tok_o.token_line      = head.token_line;
  assign tok_o.token_col       = head.token_col;
  assign tok_o.bool_val        = head.bool_val;
  assign tok_o.num_val         = head.num_val;
  assign tok_o.ident_text      = head.ident_text;
  assign tok_o.ident_len       = head.ident_len;
  assign tok_o.ident_truncated = head.ident_truncated;
  assign tok_o.last_of_run     = head.last_of_run;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for keyword_number_lexer_top: streams text bytes and end-of-text
// items, predicts every token and compares it field by field
// depends on kwl_pkg, kwl_in_if, kwl_out_if and the lexer rtl

module testbench;
  import kwl_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 165;

  // keyword spellings, first byte in the low bits
  localparam logic [63:0] SPELL_REPEAT = 64'h0000_7461_6570_6572;
  localparam logic [63:0] SPELL_IF     = 64'h0000_0000_0000_6669;
  localparam logic [63:0] SPELL_DEF    = 64'h0000_0000_0066_6564;
  localparam logic [63:0] SPELL_TRUE   = 64'h0000_0000_6575_7274;
  localparam logic [63:0] SPELL_FALSE  = 64'h0000_0065_736C_6166;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_WORD, SCAN_NUM, SCAN_DEAD} scan_e;
  typedef enum logic [1:0] {SFX_NONE, SFX_S, SFX_BAD} sfx_e;

  // one row of the directed table; typed rows carry their token, the rest use the predictor
  typedef struct packed {
    logic        req;
    logic [7:0]  ch;
    logic        typed;
    kind_e       kind;
    logic [15:0] line;
    logic [15:0] col;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [24] = '{
    // every punctuation token straight after reset
    '{REQ_CHAR, CH_LPAREN,  1'b1, K_LPAREN, 16'd1, 16'd1},
    '{REQ_CHAR, CH_RPAREN,  1'b1, K_RPAREN, 16'd1, 16'd2},
    '{REQ_CHAR, CH_LBRACE,  1'b1, K_LBRACE, 16'd1, 16'd3},
    '{REQ_CHAR, CH_RBRACE,  1'b1, K_RBRACE, 16'd1, 16'd4},
    '{REQ_CHAR, CH_COMMA,   1'b1, K_COMMA,  16'd1, 16'd5},
    // tab only moves the column
    '{REQ_CHAR, 8'h09,      1'b0, K_EOF,    16'd0, 16'd0},
    // duration ended by a comma: two tokens from one item
    '{REQ_CHAR, "7",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, CH_SUFFIX,  1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, CH_COMMA,   1'b0, K_EOF,    16'd0, 16'd0},
    // end of text flushes a pending word, then eof
    '{REQ_CHAR, "Z",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_EOT,  8'h00,      1'b0, K_EOF,    16'd0, 16'd0},
    // empty text after the restart
    '{REQ_EOT,  8'hA5,      1'b1, K_EOF,    16'd1, 16'd1},
    // bad number run flushed by end of text: error only, no eof
    '{REQ_CHAR, "4",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, "x",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_EOT,  8'hFF,      1'b0, K_EOF,    16'd0, 16'd0},
    // high byte is no letter; afterwards everything is swallowed until end of text
    '{REQ_CHAR, 8'hFF,      1'b1, K_ERROR,  16'd1, 16'd1},
    '{REQ_CHAR, "a",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_EOT,  8'h00,      1'b0, K_EOF,    16'd0, 16'd0},
    // keyword on the second line, closed by punctuation
    '{REQ_CHAR, CH_NEWLINE, 1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, "d",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, "e",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, "f",        1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_CHAR, CH_LPAREN,  1'b0, K_EOF,    16'd0, 16'd0},
    '{REQ_EOT,  8'h00,      1'b0, K_EOF,    16'd0, 16'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  kwl_in_if  req_if ();
  kwl_out_if tok_if ();

  keyword_number_lexer_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .tok_o  (tok_if)
  );

  always #10 clk_i = ~clk_i;

  // lexer state as the predictor sees it
  scan_e       scan_mode;
  sfx_e        suffix;
  logic [15:0] line_no;
  logic [15:0] col_no;
  logic [15:0] run_line;
  logic [15:0] run_col;
  logic [63:0] word_bytes;
  logic [7:0]  word_cnt;
  logic [62:0] value_acc;

  token_t run_toks [$];  // tokens caused by the item being accepted
  token_t tok_q [$];     // tokens still owed by the block, oldest first

  int send_idle_pct;
  int recv_idle_pct;
  int live_items;
  int fail_cnt;
  int cycle_cnt;

  // character classes, ascii only
  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_decimal(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // position counters stick at the top
  function automatic logic [15:0] advance(logic [15:0] v);
    return (v == POS_MAX) ? v : v + 16'd1;
  endfunction

  function automatic token_t plain_token(kind_e k, logic [15:0] ln, logic [15:0] cl);
    token_t t;
    t = '0;
    t.token_kind = k;
    t.token_line = ln;
    t.token_col  = cl;
    return t;
  endfunction

  function automatic void lexer_restart();
    scan_mode  = SCAN_IDLE;
    suffix     = SFX_NONE;
    line_no    = 16'd1;
    col_no     = 16'd1;
    run_line   = 16'd1;
    run_col    = 16'd1;
    word_bytes = '0;
    word_cnt   = '0;
    value_acc  = '0;
  endfunction

  // a letter run ends: keyword, boolean or identifier
  function automatic void close_word();
    token_t t;
    t = plain_token(K_IDENT, run_line, run_col);
    if (word_cnt == 8'd6 && word_bytes == SPELL_REPEAT) t.token_kind = K_REPEAT;
    else if (word_cnt == 8'd2 && word_bytes == SPELL_IF) t.token_kind = K_IF;
    else if (word_cnt == 8'd3 && word_bytes == SPELL_DEF) t.token_kind = K_DEF;
    else if (word_cnt == 8'd4 && word_bytes == SPELL_TRUE) begin
      t.token_kind = K_BOOL;
      t.bool_val   = 1'b1;
    end else if (word_cnt == 8'd5 && word_bytes == SPELL_FALSE) t.token_kind = K_BOOL;
    else begin
      t.ident_text      = word_bytes;
      t.ident_len       = word_cnt;
      t.ident_truncated = word_cnt > IDENT_CHARS;
    end
    run_toks.push_back(t);
    scan_mode = SCAN_IDLE;
  endfunction

  // a digit run ends: number, duration, or error that kills the text
  function automatic void close_number();
    token_t t;
    if (suffix == SFX_BAD) begin
      run_toks.push_back(plain_token(K_ERROR, run_line, run_col));
      scan_mode = SCAN_DEAD;
    end else begin
      if (suffix == SFX_S) t = plain_token(K_DURATION, run_line, run_col);
      else t = plain_token(K_NUMBER, run_line, run_col);
      t.num_val = value_acc;
      run_toks.push_back(t);
      scan_mode = SCAN_IDLE;
    end
  endfunction

  // a byte seen between tokens
  function automatic void scan_fresh(logic [7:0] c);
    kind_e k;
    logic  punct;
    k = K_EOF;
    punct = 1'b1;
    if (is_blank(c)) begin
      if (c == CH_NEWLINE) begin
        col_no  = 16'd1;
        line_no = advance(line_no);
      end else begin
        col_no = advance(col_no);
      end
      return;
    end
    case (c)
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_LBRACE: k = K_LBRACE;
      CH_RBRACE: k = K_RBRACE;
      CH_COMMA:  k = K_COMMA;
      default:   punct = 1'b0;
    endcase
    if (punct) begin
      run_toks.push_back(plain_token(k, line_no, col_no));
      col_no = advance(col_no);
      return;
    end
    run_line = line_no;
    run_col  = col_no;
    if (is_letter(c)) begin
      word_bytes = {56'd0, c};
      word_cnt   = 8'd1;
      scan_mode  = SCAN_WORD;
      col_no     = advance(col_no);
    end else if (is_decimal(c)) begin
      value_acc = 63'(c - "0");
      suffix    = SFX_NONE;
      scan_mode = SCAN_NUM;
      col_no    = advance(col_no);
    end else begin
      run_toks.push_back(plain_token(K_ERROR, line_no, col_no));
      scan_mode = SCAN_DEAD;
    end
  endfunction

  // works out the tokens of one accepted item into run_toks
  function automatic void predict_tokens(logic req, logic [7:0] c);
    logic [62:0] digit;
    run_toks.delete();
    if (req == REQ_EOT) begin
      if (scan_mode == SCAN_WORD) close_word();
      else if (scan_mode == SCAN_NUM) close_number();
      if (scan_mode != SCAN_DEAD) run_toks.push_back(plain_token(K_EOF, line_no, col_no));
      lexer_restart();
    end else begin
      case (scan_mode)
        SCAN_DEAD: ;
        SCAN_WORD: begin
          if (is_letter(c)) begin
            if (word_cnt < IDENT_CHARS) word_bytes[8*word_cnt +: 8] = c;
            if (word_cnt != 8'd255) word_cnt = word_cnt + 8'd1;
            col_no = advance(col_no);
          end else begin
            close_word();
            scan_fresh(c);
          end
        end
        SCAN_NUM: begin
          if (is_letter(c) || is_decimal(c)) begin
            if (suffix == SFX_NONE) begin
              if (is_decimal(c)) begin
                digit = 63'(c - "0");
                if (value_acc > (NUM_MAX - digit) / 63'd10) value_acc = NUM_MAX;
                else value_acc = value_acc * 63'd10 + digit;
              end else if (c == CH_SUFFIX) begin
                suffix = SFX_S;
              end else begin
                suffix = SFX_BAD;
              end
            end else begin
              suffix = SFX_BAD;
            end
            col_no = advance(col_no);
          end else begin
            close_number();
            if (scan_mode != SCAN_DEAD) scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
    end
  endfunction

  // moves the tokens of this item to the owed list, flagging the last one
  function automatic void owe_tokens();
    token_t t;
    foreach (run_toks[i]) begin
      t = run_toks[i];
      t.last_of_run = (i == run_toks.size() - 1);
      tok_q.push_back(t);
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  // one item on the input channel; gaps drawn per cycle, result predicted at acceptance
  task automatic send_item(input logic req, input logic [7:0] c,
                           input logic use_typed = 1'b0, input token_t typed_tok = '0);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid    = 1'b1;
    req_if.req_type = req;
    req_if.ch       = c;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    // bytes swallowed after an error do not count toward the item budget
    if (req == REQ_EOT || scan_mode != SCAN_DEAD) live_items++;
    predict_tokens(req, c);
    if (use_typed) begin
      run_toks.delete();
      run_toks.push_back(typed_tok);
    end
    owe_tokens();
  endtask

  task automatic send_char(input logic [7:0] c);
    send_item(REQ_CHAR, c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] random_letter();
    if ($urandom_range(3) == 0) return "A" + 8'($urandom_range(25));
    return "a" + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] random_digit();
    return "0" + 8'($urandom_range(9));
  endfunction

  // space and newline most of the time, the rarer control blanks too
  function automatic logic [7:0] random_blank();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return CH_SPACE;
    if (pick < 7) return CH_NEWLINE;
    return 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] random_punct();
    case ($urandom_range(4))
      0:       return CH_LPAREN;
      1:       return CH_RPAREN;
      2:       return CH_LBRACE;
      3:       return CH_RBRACE;
      default: return CH_COMMA;
    endcase
  endfunction

  // what closes a word or number run; now and then nothing, so runs merge
  task automatic send_separator();
    int pick;
    pick = $urandom_range(9);
    if (pick >= 1 && pick <= 6) send_char(random_blank());
    else if (pick > 6) send_char(random_punct());
  endtask

  // one text of well-formed lexemes with some noise, closed by end of text
  task automatic random_text(input int n_lex);
    int    pick;
    string s;
    for (int i = 0; i < n_lex; i++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        case ($urandom_range(4))
          0:       s = "repeat";
          1:       s = "if";
          2:       s = "def";
          3:       s = "true";
          default: s = "false";
        endcase
        // near miss: one letter too many
        if ($urandom_range(3) == 0) s = {s, "e"};
        send_text(s);
        send_separator();
      end else if (pick < 30) begin
        // mostly short identifiers, rarely long enough to pin the length at its limit
        if ($urandom_range(39) == 0) repeat ($urandom_range(250, 300)) send_char(random_letter());
        else repeat ($urandom_range(1, 12)) send_char(random_letter());
        send_separator();
      end else if (pick < 46) begin
        case ($urandom_range(9))
          0:       send_text("9223372036854775807");
          1:       send_text("9223372036854775808");
          2:       repeat ($urandom_range(19, 25)) send_char(random_digit());
          default: repeat ($urandom_range(1, 6)) send_char(random_digit());
        endcase
        if ($urandom_range(2) == 0) send_char(CH_SUFFIX);
        send_separator();
      end else if (pick < 64) begin
        send_char(random_punct());
      end else if (pick < 90) begin
        send_char(random_blank());
      end else if (pick < 95) begin
        // broken number run: a letter after the digits, or after the suffix
        repeat ($urandom_range(1, 3)) send_char(random_digit());
        if ($urandom_range(1) == 0) send_char(CH_SUFFIX);
        send_char(random_letter());
        send_separator();
      end else begin
        send_char(8'($urandom_range(255)));
      end
    end
    send_item(REQ_EOT, 8'($urandom_range(255)));
  endtask

  // lower valid and hold off until every owed token has come back
  task automatic settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    while (tok_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver side: ready drawn fresh at every falling edge
  always @(negedge clk_i) begin
    tok_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // every accepted token is matched against the oldest owed one
  always @(posedge clk_i) begin : token_check
    token_t got;
    token_t want;
    if (rst_ni && tok_if.valid && tok_if.ready) begin
      got.token_kind      = kind_e'(tok_if.token_kind);
      got.token_line      = tok_if.token_line;
      got.token_col       = tok_if.token_col;
      got.bool_val        = tok_if.bool_val;
      got.num_val         = tok_if.num_val;
      got.ident_text      = tok_if.ident_text;
      got.ident_len       = tok_if.ident_len;
      got.ident_truncated = tok_if.ident_truncated;
      got.last_of_run     = tok_if.last_of_run;
      if (tok_q.size() == 0) begin
        $display("%0t: token with nothing owed, kind %0d at line %0d col %0d", $time,
                 got.token_kind, got.token_line, got.token_col);
        fail_cnt++;
      end else begin
        want = tok_q.pop_front();
        check_field("token_kind", 64'(want.token_kind), 64'(got.token_kind));
        check_field("token_line", 64'(want.token_line), 64'(got.token_line));
        check_field("token_col", 64'(want.token_col), 64'(got.token_col));
        check_field("bool_val", 64'(want.bool_val), 64'(got.bool_val));
        check_field("num_val", 64'(want.num_val), 64'(got.num_val));
        check_field("ident_text", want.ident_text, got.ident_text);
        check_field("ident_len", 64'(want.ident_len), 64'(got.ident_len));
        check_field("ident_truncated", 64'(want.ident_truncated), 64'(got.ident_truncated));
        check_field("last_of_run", 64'(want.last_of_run), 64'(got.last_of_run));
      end
    end
  end

  // watchdog, far above the slowest correct run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.req_type = REQ_CHAR;
    req_if.ch       = 8'h00;
    tok_if.ready    = 1'b0;
    cycle_cnt       = 0;
    fail_cnt        = 0;
    live_items      = 0;
    send_idle_pct   = 33;
    recv_idle_pct   = 80;
    lexer_restart();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table, under the first idling pattern
    foreach (DIR_ROWS[i]) begin
      send_item(DIR_ROWS[i].req, DIR_ROWS[i].ch, DIR_ROWS[i].typed,
                plain_token(DIR_ROWS[i].kind, DIR_ROWS[i].line, DIR_ROWS[i].col));
    end

    // random texts: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 80;
        end
        1: begin
          send_idle_pct = 80;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      while (live_items < ITEMS_PER_PHASE * (phase + 1)) random_text($urandom_range(0, 12));
      settle();
    end

    // quiet tail: nothing owed, catch any stray token
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/kwl_pkg.sv
hw/rtl/kwl_in_if.sv
hw/rtl/kwl_out_if.sv
hw/rtl/kwl_scan.sv
hw/rtl/kwl_outq.sv
hw/rtl/keyword_number_lexer_top.sv
tb/sv/testbench.sv
